// File: src/laplacian_3x3_rgba_filter_defines.svh
// Assertion macros for the checker file.
`ifndef LAPLACIAN_3X3_RGBA_FILTER_DEFINES_SVH
`define LAPLACIAN_3X3_RGBA_FILTER_DEFINES_SVH

// Clocked property, disabled while reset is asserted.
`define LAP3_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lap3 assertion failed");

// Clocked property that is checked during reset too.
`define LAP3_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("lap3 assertion failed");

`endif

// File: src/lap3_pkg.sv
package lap3_pkg;

    // Line buffer depth (longest supported row).
    localparam int MaxWidth = 1024;
    localparam int AddrW    = $clog2(MaxWidth);
    localparam int WidthW   = $clog2(MaxWidth + 1);

    localparam int FwW      = 11;
    localparam int HeightW  = 16;
    localparam int RowW     = HeightW + 1;   // row counter runs to height + 1
    localparam int CfgDataW = 16;
    localparam int CfgIdxW  = 2;

    localparam int NumLanes = 4;
    localparam int ChanW    = 8;
    localparam int PixW     = NumLanes * ChanW;
    localparam int ChanMax  = 255;

    localparam logic [FwW-1:0]     FwReset = 11'd640;
    localparam logic [HeightW-1:0] FhReset = 16'd480;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgFrameWidth     = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgFrameHeight    = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgCenterNegative = 2'd2;

    typedef logic [PixW-1:0] pixel_t;

    // Per-item position info from the counters to the datapath
    typedef struct packed {
        logic emit;
        logic use_up;
        logic use_lf;
        logic use_rt;
        logic use_dn;
        logic last;
    } pos_t;

    // 3x3 cross neighborhood around the output pixel
    typedef struct packed {
        pixel_t up;
        pixel_t lf;
        pixel_t ct;
        pixel_t rt;
        pixel_t dn;
    } win_t;

endpackage

// File: src/lap3_ctrl.sv
module lap3_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic                          cfg_we,
    input  logic [lap3_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [lap3_pkg::CfgDataW-1:0] cfg_data,
    output logic [lap3_pkg::AddrW-1:0]    addr,
    output lap3_pkg::pos_t                pos,
    output logic                          center_negative
);

    logic [lap3_pkg::FwW-1:0]     fw_reg;
    logic [lap3_pkg::HeightW-1:0] fh_reg;
    logic                         neg_reg;
    logic [lap3_pkg::AddrW-1:0]   col_reg;
    logic [lap3_pkg::RowW-1:0]    row_reg;

    logic [lap3_pkg::WidthW-1:0]  w;
    logic [lap3_pkg::RowW-1:0]    h;
    logic [lap3_pkg::WidthW-1:0]  c;
    logic [lap3_pkg::WidthW-1:0]  c1;
    logic [lap3_pkg::WidthW-1:0]  px;
    logic [lap3_pkg::RowW-1:0]    py;
    logic [lap3_pkg::RowW-1:0]    r_inc;
    logic                         emit_pos;
    logic [lap3_pkg::AddrW-1:0]   col_next;
    logic [lap3_pkg::RowW-1:0]    row_next;

    // effective geometry: width clamped to 1..MaxWidth, height zero taken as 1
    always_comb begin
        priority if (fw_reg == '0) begin
            w = lap3_pkg::WidthW'(1);
        end else if (32'(fw_reg) > lap3_pkg::MaxWidth) begin
            w = lap3_pkg::WidthW'(lap3_pkg::MaxWidth);
        end else begin
            w = lap3_pkg::WidthW'(fw_reg);
        end
        h = (fh_reg == '0) ? lap3_pkg::RowW'(1) : lap3_pkg::RowW'(fh_reg);
    end

    always_comb begin
        c        = (lap3_pkg::WidthW'(col_reg) >= w) ? '0 : lap3_pkg::WidthW'(col_reg);
        emit_pos = (row_reg >= lap3_pkg::RowW'(2)) ||
                   ((row_reg == lap3_pkg::RowW'(1)) && (c != '0));
        px       = (c == '0) ? w - 1'b1 : c - 1'b1;
        py       = (c == '0) ? row_reg - lap3_pkg::RowW'(2) : row_reg - 1'b1;

        pos.emit   = emit_pos && (py < h);
        pos.use_up = (py != '0);
        pos.use_lf = (px != '0);
        pos.use_rt = ((px + 1'b1) < w);
        pos.use_dn = ((py + 1'b1) < h);
        pos.last   = pos.emit && (px == w - 1'b1) && (py == h - 1'b1);

        c1 = c + 1'b1;
        if (c1 >= w) begin
            col_next = '0;
            r_inc    = row_reg + 1'b1;
        end else begin
            col_next = c1[lap3_pkg::AddrW-1:0];
            r_inc    = row_reg;
        end
        row_next = r_inc;
        if (pos.last || (r_inc > h + 1'b1)) begin
            col_next = '0;
            row_next = '0;
        end
    end

    assign addr            = c[lap3_pkg::AddrW-1:0];
    assign center_negative = neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg  <= lap3_pkg::FwReset;
            fh_reg  <= lap3_pkg::FhReset;
            neg_reg <= 1'b0;
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lap3_pkg::CfgFrameWidth: begin
                    fw_reg  <= cfg_data[lap3_pkg::FwW-1:0];
                    col_reg <= '0;
                    row_reg <= '0;
                end
                lap3_pkg::CfgFrameHeight: begin
                    fh_reg  <= cfg_data[lap3_pkg::HeightW-1:0];
                    col_reg <= '0;
                    row_reg <= '0;
                end
                lap3_pkg::CfgCenterNegative: begin
                    neg_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: src/lap3_line_buf.sv
module lap3_line_buf (
    input  logic                       aclk,
    input  logic                       accept,
    input  logic [lap3_pkg::AddrW-1:0] addr,
    input  lap3_pkg::pixel_t           pix,
    output lap3_pkg::win_t             win
);

    lap3_pkg::pixel_t mid_mem   [lap3_pkg::MaxWidth];
    lap3_pkg::pixel_t above_mem [lap3_pkg::MaxWidth];

    lap3_pkg::pixel_t rt_reg;     // also the running center pixel
    lap3_pkg::pixel_t up_reg;
    lap3_pkg::pixel_t left_reg;
    lap3_pkg::pixel_t prev_reg;
    lap3_pkg::pixel_t ct_reg;
    lap3_pkg::pixel_t lf_reg;
    lap3_pkg::pixel_t dn_reg;

    // read-before-write at the same column
    always_ff @(posedge aclk) begin
        if (accept) begin
            mid_mem[addr] <= pix;
            rt_reg        <= mid_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            above_mem[addr] <= rt_reg;
            up_reg          <= above_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ct_reg   <= rt_reg;
            lf_reg   <= left_reg;
            left_reg <= rt_reg;
            dn_reg   <= prev_reg;
            prev_reg <= pix;
        end
    end

    assign win.up = up_reg;
    assign win.lf = lf_reg;
    assign win.ct = ct_reg;
    assign win.rt = rt_reg;
    assign win.dn = dn_reg;

endmodule

// File: src/lap3_lane.sv
module lap3_lane (
    input  logic [lap3_pkg::ChanW-1:0] up_chan,
    input  logic [lap3_pkg::ChanW-1:0] lf_chan,
    input  logic [lap3_pkg::ChanW-1:0] ct_chan,
    input  logic [lap3_pkg::ChanW-1:0] rt_chan,
    input  logic [lap3_pkg::ChanW-1:0] dn_chan,
    input  lap3_pkg::pos_t             flags,
    input  logic                       center_negative,
    output logic [lap3_pkg::ChanW-1:0] result
);

    localparam int SumW = lap3_pkg::ChanW + 2;

    logic [SumW-1:0]        nb;
    logic [SumW-1:0]        ct4;
    logic signed [SumW:0]   diff;

    always_comb begin
        nb = SumW'(up_chan & {lap3_pkg::ChanW{flags.use_up}}) +
             SumW'(lf_chan & {lap3_pkg::ChanW{flags.use_lf}}) +
             SumW'(rt_chan & {lap3_pkg::ChanW{flags.use_rt}}) +
             SumW'(dn_chan & {lap3_pkg::ChanW{flags.use_dn}});
        ct4 = {ct_chan, 2'b00};
        if (center_negative) begin
            diff = $signed({1'b0, nb}) - $signed({1'b0, ct4});
        end else begin
            diff = $signed({1'b0, ct4}) - $signed({1'b0, nb});
        end
        priority if (diff < 0) begin
            result = '0;
        end else if (diff > (SumW + 1)'(lap3_pkg::ChanMax)) begin
            result = lap3_pkg::ChanW'(lap3_pkg::ChanMax);
        end else begin
            result = diff[lap3_pkg::ChanW-1:0];
        end
    end

endmodule

// File: src/laplacian_3x3_rgba_filter.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid / s_ready  s_action, s_in_red/green/blue/alpha
// m_        out  m_valid / m_ready  m_out_red/green/blue/alpha, m_frame_last
// cfg_      in   cfg_we             cfg_index, cfg_data (no read-back)
//
// One item per clock sustained while m_ready stays high. The edge that takes an
// item loads the window stage; the result then moves into the output register.
// Each line buffer has one read/write port and one column is touched per item.
// Reset (aresetn, sync, low) clears counters, the pipeline and the registers
// to width 640, height 480, mode 0; line buffers need no clearing pass.
// An m_ stall parks one result in the window stage, then s_ready drops.
module laplacian_3x3_rgba_filter (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [7:0]                    s_in_red,
    input  logic [7:0]                    s_in_green,
    input  logic [7:0]                    s_in_blue,
    input  logic [7:0]                    s_in_alpha,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_red,
    output logic [7:0]                    m_out_green,
    output logic [7:0]                    m_out_blue,
    output logic [7:0]                    m_out_alpha,
    output logic                          m_frame_last,

    input  logic                          cfg_we,
    input  logic [lap3_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [lap3_pkg::CfgDataW-1:0] cfg_data
);

    logic                       accept;
    logic [lap3_pkg::AddrW-1:0] addr;
    lap3_pkg::pos_t             pos;
    logic                       center_negative;
    lap3_pkg::pixel_t           pix;
    lap3_pkg::win_t             win;

    // window stage: holds the item while the line buffer read settles
    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    lap3_pkg::pos_t             s1_pos_reg;
    logic                       s1_move;

    // output register (merge of the four lanes)
    logic                       m_valid_reg;
    logic [lap3_pkg::ChanW-1:0] out_chan_reg [lap3_pkg::NumLanes];
    logic                       last_reg;
    logic [lap3_pkg::ChanW-1:0] lane_res     [lap3_pkg::NumLanes];

    assign s1_move = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_move;
    assign accept  = s_valid && s_ready;

    // flush items carry a zero pixel
    assign pix = s_action ? '0 : {s_in_alpha, s_in_blue, s_in_green, s_in_red};

    lap3_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .addr            (addr),
        .pos             (pos),
        .center_negative (center_negative)
    );

    lap3_line_buf u_line_buf (
        .aclk   (aclk),
        .accept (accept),
        .addr   (addr),
        .pix    (pix),
        .win    (win)
    );

    // one lane per channel: red, green, blue, alpha
    for (genvar k = 0; k < lap3_pkg::NumLanes; k++) begin : g_lane
        lap3_lane u_lane (
            .up_chan         (win.up[k*lap3_pkg::ChanW +: lap3_pkg::ChanW]),
            .lf_chan         (win.lf[k*lap3_pkg::ChanW +: lap3_pkg::ChanW]),
            .ct_chan         (win.ct[k*lap3_pkg::ChanW +: lap3_pkg::ChanW]),
            .rt_chan         (win.rt[k*lap3_pkg::ChanW +: lap3_pkg::ChanW]),
            .dn_chan         (win.dn[k*lap3_pkg::ChanW +: lap3_pkg::ChanW]),
            .flags           (s1_pos_reg),
            .center_negative (center_negative),
            .result          (lane_res[k])
        );
    end

    // items that produce no result never enter the window stage
    always_comb begin
        if (accept) begin
            s1_valid_next = pos.emit;
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pos_reg <= pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            out_chan_reg <= lane_res;
            last_reg     <= s1_pos_reg.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_red    = out_chan_reg[0];
    assign m_out_green  = out_chan_reg[1];
    assign m_out_blue   = out_chan_reg[2];
    assign m_out_alpha  = out_chan_reg[3];
    assign m_frame_last = last_reg;

endmodule

// File: src/lap3_checker.sv
`include "laplacian_3x3_rgba_filter_defines.svh"

module lap3_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_red,
    input  logic [7:0] m_out_green,
    input  logic [7:0] m_out_blue,
    input  logic [7:0] m_out_alpha,
    input  logic       m_frame_last
);

    logic [32:0] m_payload;

    assign m_payload = {m_out_red, m_out_green, m_out_blue, m_out_alpha, m_frame_last};

    // a pending result is held until taken
    `LAP3_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid)

    `LAP3_ASSERT(a_out_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_payload))

    // reset empties the output register
    `LAP3_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid)

    // a fresh result always traces back to an item that was taken and passed the window stage
    `LAP3_ASSERT(a_out_from_item, aclk, aresetn, $rose(m_valid) |-> $past(s_valid && s_ready, 2))

endmodule

bind laplacian_3x3_rgba_filter lap3_checker u_lap3_checker (.*);

// File: tb/laplacian_3x3_rgba_filter_tb.sv
`timescale 1ns / 1ps

module laplacian_3x3_rgba_filter_tb;

    localparam int HalfPeriod  = 5;
    localparam int CycleLimit  = 400000;
    localparam int ReportLimit = 10;
    localparam int RandomItems = 900;

    // index 3 has no register behind it; a write there must change nothing
    localparam logic [lap3_pkg::CfgIdxW-1:0] CfgNoRegister = 2'd3;

    // red in bits 7:0, then green, blue, alpha
    typedef bit [lap3_pkg::PixW-1:0] rgba_word_t;

    typedef struct packed {
        bit         flush;
        rgba_word_t rgba;
    } pixel_item_t;

    typedef struct packed {
        rgba_word_t rgba;
        bit         last;
    } filtered_px_t;

    // ------------------------------------------------------------------
    // DUT signals; the inputs the bench drives start at known values from time zero
    // ------------------------------------------------------------------
    logic                          aclk         = 1'b0;
    logic                          aresetn      = 1'b0;
    logic                          s_valid      = 1'b0;
    logic                          s_ready;
    logic                          s_action     = 1'b0;
    logic [7:0]                    s_in_red     = 8'd0;
    logic [7:0]                    s_in_green   = 8'd0;
    logic [7:0]                    s_in_blue    = 8'd0;
    logic [7:0]                    s_in_alpha   = 8'd0;
    logic                          m_valid;
    logic                          m_ready      = 1'b0;
    logic [7:0]                    m_out_red;
    logic [7:0]                    m_out_green;
    logic [7:0]                    m_out_blue;
    logic [7:0]                    m_out_alpha;
    logic                          m_frame_last;
    logic                          cfg_we       = 1'b0;
    logic [lap3_pkg::CfgIdxW-1:0]  cfg_index    = '0;
    logic [lap3_pkg::CfgDataW-1:0] cfg_data     = '0;

    laplacian_3x3_rgba_filter u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_in_red     (s_in_red),
        .s_in_green   (s_in_green),
        .s_in_blue    (s_in_blue),
        .s_in_alpha   (s_in_alpha),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_red    (m_out_red),
        .m_out_green  (m_out_green),
        .m_out_blue   (m_out_blue),
        .m_out_alpha  (m_out_alpha),
        .m_frame_last (m_frame_last),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #HalfPeriod aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    pixel_item_t  pending_q[$];     // items waiting to be offered on s_
    filtered_px_t filtered_q[$];    // predicted m_ items, oldest first
    bit           item_taken   = 1'b0;
    int           mismatch_count = 0;
    int           results_seen   = 0;
    int unsigned  items_queued   = 0;
    int           cycle_count    = 0;

    // ------------------------------------------------------------------
    // Predictor state: two line stores plus left/center form the delay
    // line of 2*width+2 pixels; counters give the position of the next item.
    // ------------------------------------------------------------------
    rgba_word_t                 above_line  [lap3_pkg::MaxWidth];
    rgba_word_t                 middle_line [lap3_pkg::MaxWidth];
    rgba_word_t                 left_px     = '0;
    rgba_word_t                 center_px   = '0;
    int unsigned                col_pos     = 0;
    int unsigned                row_pos     = 0;
    bit [lap3_pkg::FwW-1:0]     width_reg   = lap3_pkg::FwReset;
    bit [lap3_pkg::HeightW-1:0] height_reg  = lap3_pkg::FhReset;
    bit                         negative_reg = 1'b0;

    // One channel of the cross kernel; skipped neighbors act as zero padding.
    function automatic bit [7:0] laplace_lane(bit [7:0] up, bit [7:0] lf,
                                              bit [7:0] ct, bit [7:0] rt,
                                              bit [7:0] dn,
                                              bit use_up, bit use_lf, bit use_rt,
                                              bit use_dn, bit neg);
        int nb;
        int sum;
        nb = 0;
        if (use_up) nb += up;
        if (use_lf) nb += lf;
        if (use_rt) nb += rt;
        if (use_dn) nb += dn;
        sum = neg ? nb - 4 * int'(ct) : 4 * int'(ct) - nb;
        if (sum < 0)   sum = 0;
        if (sum > lap3_pkg::ChanMax) sum = lap3_pkg::ChanMax;
        return 8'(sum);
    endfunction

    // Advance the filter by one accepted item; queue the result it releases.
    task automatic advance_filter(input bit flush, input rgba_word_t px_in);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        int unsigned  px;
        int unsigned  py;
        rgba_word_t   pix;
        rgba_word_t   up;
        rgba_word_t   lf;
        rgba_word_t   ct;
        rgba_word_t   rt;
        rgba_word_t   dn;
        bit           last;
        filtered_px_t res;
        w = (width_reg == 0) ? 1 :
            (width_reg > lap3_pkg::MaxWidth) ? lap3_pkg::MaxWidth : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        c = (col_pos >= w) ? 0 : col_pos;
        r = row_pos;
        pix = flush ? '0 : px_in;     // flush inside the image is a black pixel

        rt = middle_line[c];
        dn = middle_line[(c + w - 1) % w];
        ct = center_px;
        lf = left_px;
        up = above_line[c];
        last = 1'b0;

        if (r >= 2 || (r == 1 && c >= 1)) begin
            px = (c == 0) ? w - 1 : c - 1;
            py = (c == 0) ? r - 2 : r - 1;
            // rows past the bottom edge are drain positions, no result
            if (py < h) begin
                for (int k = 0; k < lap3_pkg::NumLanes; k++) begin
                    res.rgba[8*k +: 8] = laplace_lane(up[8*k +: 8], lf[8*k +: 8],
                                                      ct[8*k +: 8], rt[8*k +: 8],
                                                      dn[8*k +: 8], py > 0, px > 0,
                                                      px + 1 < w, py + 1 < h,
                                                      negative_reg);
                end
                last = (px == w - 1) && (py == h - 1);
                res.last = last;
                filtered_q.push_back(res);
            end
        end

        above_line[c]  = center_px;
        left_px        = center_px;
        center_px      = rt;
        middle_line[c] = pix;

        c++;
        if (c >= w) begin
            c = 0;
            r++;
        end
        // frame done: next item opens a new frame
        if (last || r > h + 1) begin
            c = 0;
            r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            if (mismatch_count < ReportLimit)
                $display("mismatch on %s at result %0d: expected %0d, got %0d",
                         what, results_seen, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: samples both channels and the register port at the rising
    // edge. Outputs are checked before the new item is predicted, so a
    // same-edge pop/push never depends on process order.
    // ------------------------------------------------------------------
    filtered_px_t oldest;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (filtered_q.size() == 0) begin
                    if (mismatch_count < ReportLimit)
                        $display("result %0d arrived with nothing expected: %0d %0d %0d %0d %s %0b",
                                 results_seen, m_out_red, m_out_green, m_out_blue,
                                 m_out_alpha, "last", m_frame_last);
                    mismatch_count++;
                end else begin
                    oldest = filtered_q.pop_front();
                    check_field("red",        oldest.rgba[7:0],   m_out_red);
                    check_field("green",      oldest.rgba[15:8],  m_out_green);
                    check_field("blue",       oldest.rgba[23:16], m_out_blue);
                    check_field("alpha",      oldest.rgba[31:24], m_out_alpha);
                    check_field("frame_last", oldest.last,        m_frame_last);
                end
                results_seen++;
            end

            // geometry writes restart the frame; the line stores keep contents
            if (cfg_we) begin
                case (cfg_index)
                    lap3_pkg::CfgFrameWidth: begin
                        width_reg = cfg_data[lap3_pkg::FwW-1:0];
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    lap3_pkg::CfgFrameHeight: begin
                        height_reg = cfg_data[lap3_pkg::HeightW-1:0];
                        col_pos    = 0;
                        row_pos    = 0;
                    end
                    lap3_pkg::CfgCenterNegative: begin
                        negative_reg = cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end

            if (s_valid && s_ready)
                advance_filter(s_action, {s_in_alpha, s_in_blue, s_in_green, s_in_red});
        end
        item_taken <= aresetn && s_valid && s_ready;
    end

    // ------------------------------------------------------------------
    // Driver: offers queued items in bursts with random gaps. Payload and
    // valid change only at the falling edge, and only once the current
    // item has been taken.
    // ------------------------------------------------------------------
    pixel_item_t next_item;
    int          burst_left = 0;
    int          gap_left   = 0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || item_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_q.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                next_item = pending_q.pop_front();
                s_action   <= next_item.flush;
                s_in_red   <= next_item.rgba[7:0];
                s_in_green <= next_item.rgba[15:8];
                s_in_blue  <= next_item.rgba[23:16];
                s_in_alpha <= next_item.rgba[31:24];
                s_valid    <= 1'b1;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 64);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;                     // back-to-back
                        1:       gap_left = $urandom_range(8, 24); // long pause
                        default: gap_left = $urandom_range(1, 4);
                    endcase
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows one of four patterns, each kept for a random
    // stretch. Twice it holds off for a long stretch while the sender still
    // has plenty queued, so the pipeline backs up into s_ready.
    // ------------------------------------------------------------------
    int hold_left    = 0;
    int pattern_left = 0;
    int pattern_kind = 0;
    int holds_done   = 0;
    int hold_mark    = 100;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (holds_done < 2 && results_seen >= hold_mark &&
                     pending_q.size() >= 40) begin
            hold_left = $urandom_range(150, 300);
            holds_done++;
            hold_mark += 400;
            m_ready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_kind = $urandom_range(0, 3);
                pattern_left = $urandom_range(10, 80);
            end
            pattern_left--;
            case (pattern_kind)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [lap3_pkg::CfgIdxW-1:0]  idx,
                             input logic [lap3_pkg::CfgDataW-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic queue_item(input bit flush, input bit [7:0] red, input bit [7:0] green,
                              input bit [7:0] blue, input bit [7:0] alpha);
        pixel_item_t it;
        it.flush = flush;
        it.rgba  = {alpha, blue, green, red};
        pending_q.push_back(it);
        items_queued++;
    endtask

    // style 0: uniform, 1: only 0/255, 2: smooth around a base (keeps sums
    // inside the unsaturated range more often)
    function automatic bit [7:0] lane_value(int style, int base);
        int v;
        case (style)
            0:       v = $urandom_range(0, 255);
            1:       v = $urandom_range(0, 1) ? 255 : 0;
            default: v = base + int'($urandom_range(0, 40)) - 20;
        endcase
        if (v < 0)   v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // One frame of w x h pixels plus its w+1 drain items, cut at upto.
    // A few flushes land inside the image and a few pixels in the drain.
    task automatic queue_frame(input int unsigned w, input int unsigned h,
                               input int unsigned upto);
        int unsigned n_img;
        int unsigned n_all;
        int          style;
        int          base [4];
        bit          flush;
        n_img = w * h;
        n_all = n_img + w + 1;
        if (upto < n_all) n_all = upto;
        style = $urandom_range(0, 2);
        for (int k = 0; k < 4; k++) base[k] = $urandom_range(0, 255);
        for (int unsigned i = 0; i < n_all; i++) begin
            if (i < n_img) flush = ($urandom_range(0, 99) < 4);
            else           flush = ($urandom_range(0, 99) < 80);
            queue_item(flush, lane_value(style, base[0]), lane_value(style, base[1]),
                       lane_value(style, base[2]), lane_value(style, base[3]));
        end
    endtask

    // Wait until every item is taken and every expected result has come,
    // then wait on for items still inside the pipeline.
    task automatic drain_to_idle();
        while (pending_q.size() != 0 || s_valid || filtered_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned run;
        int unsigned random_items;
        int unsigned before_run;
        int unsigned cur_w;
        int unsigned cur_h;
        int unsigned w_written;
        int unsigned n_frames;
        int unsigned full_len;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Zero width and zero height both act as 1: a 1x1 frame. Center
        // positive, so each lane is 4*pixel saturated. Second drain item is
        // a real pixel given where a flush is due.
        write_reg(lap3_pkg::CfgFrameWidth, 16'd0);
        write_reg(lap3_pkg::CfgFrameHeight, 16'd0);
        write_reg(lap3_pkg::CfgCenterNegative, 16'd0);
        queue_item(1'b0, 8'd255, 8'd0, 8'd63, 8'd64);
        queue_item(1'b1, 8'd9, 8'd9, 8'd9, 8'd9);
        queue_item(1'b0, 8'd200, 8'd17, 8'd3, 8'd250);
        drain_to_idle();

        write_reg(CfgNoRegister, 16'hFFFF);

        // 3x2 frame with extremes and a flush inside the image, once per
        // mode; the frame counters restart by themselves after frame end.
        write_reg(lap3_pkg::CfgFrameWidth, 16'd3);
        write_reg(lap3_pkg::CfgFrameHeight, 16'd2);
        for (int pass = 0; pass < 2; pass++) begin
            write_reg(lap3_pkg::CfgCenterNegative, (pass == 0) ? 16'hFFFF : 16'hFFFE);
            queue_item(1'b0, 8'd0,   8'd0,   8'd0,   8'd0);
            queue_item(1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
            queue_item(1'b1, 8'd255, 8'd128, 8'd1,   8'd77);
            queue_item(1'b0, 8'd255, 8'd0,   8'd255, 8'd0);
            queue_item(1'b0, 8'd0,   8'd255, 8'd0,   8'd255);
            queue_item(1'b0, 8'd100, 8'd60,  8'd30,  8'd128);
            queue_item(1'b1, 8'd0,   8'd0,   8'd0,   8'd0);
            queue_item(1'b1, 8'd0,   8'd0,   8'd0,   8'd0);
            queue_item(1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
            queue_item(1'b1, 8'd0,   8'd0,   8'd0,   8'd0);
            drain_to_idle();
        end

        // Runs. The first three use extreme geometry, the rest pick a
        // setting, queue several frames and drain. Some runs only flip the
        // mode, so a cut frame carries on under the other kernel sign.
        cur_w        = 3;
        cur_h        = 2;
        run          = 0;
        random_items = 0;
        while (random_items < RandomItems) begin
            before_run = items_queued;
            if (run == 0) begin
                // all width bits set, clamped to the line store depth; tallest
                // frame; cut inside the first row, so no result is due
                write_reg(lap3_pkg::CfgFrameWidth, 16'hFFFF);
                write_reg(lap3_pkg::CfgFrameHeight, 16'hFFFF);
                write_reg(lap3_pkg::CfgCenterNegative, 16'($urandom_range(0, 1)));
                cur_w = lap3_pkg::MaxWidth;
                cur_h = 65535;
                queue_frame(cur_w, cur_h, 150);
            end else if (run == 1) begin
                // widest legal line, cut inside the first row
                write_reg(lap3_pkg::CfgFrameWidth, 16'd1024);
                write_reg(lap3_pkg::CfgFrameHeight, 16'd3);
                cur_w = 1024;
                cur_h = 3;
                queue_frame(cur_w, cur_h, 100);
            end else if (run == 2) begin
                write_reg(lap3_pkg::CfgFrameWidth, 16'd1);
                write_reg(lap3_pkg::CfgFrameHeight, 16'hFFFF);
                cur_w = 1;
                cur_h = 65535;
                queue_frame(cur_w, cur_h, 60);
            end else begin
                // large geometry left by an earlier run is always replaced
                if (cur_w * cur_h > 256 || $urandom_range(0, 3) != 0) begin
                    if ($urandom_range(0, 19) == 0)      w_written = 0;
                    else if ($urandom_range(0, 9) < 7)  w_written = $urandom_range(1, 8);
                    else                                w_written = $urandom_range(9, 40);
                    cur_w = (w_written == 0) ? 1 : w_written;
                    cur_h = $urandom_range(0, 6);
                    write_reg(lap3_pkg::CfgFrameWidth, {5'($urandom), 11'(w_written)});
                    write_reg(lap3_pkg::CfgFrameHeight, 16'(cur_h));
                    if (cur_h == 0) cur_h = 1;
                end
                write_reg(lap3_pkg::CfgCenterNegative, 16'($urandom));
                n_frames = $urandom_range(2, 8);
                full_len = cur_w * cur_h + cur_w + 1;
                for (int unsigned f = 0; f < n_frames; f++) begin
                    // last frame sometimes cut short; only a geometry write restarts it
                    if (f == n_frames - 1 && $urandom_range(0, 4) == 0)
                        queue_frame(cur_w, cur_h, $urandom_range(1, full_len));
                    else
                        queue_frame(cur_w, cur_h, full_len);
                end
            end
            random_items += items_queued - before_run;
            drain_to_idle();
            run++;
        end

        drain_to_idle();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && filtered_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
